[rtl/core/pdct_pkg.sv]
// shared types and constants for the prompt/delayed coincidence tagger
package pdct_pkg;

    localparam int unsigned EnergyW  = 17;
    localparam int unsigned TimeW    = 40;
    localparam int unsigned ChannelW = 10;
    localparam int unsigned ChainW   = 32;
    localparam int unsigned HitsW    = 8;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 40;

    // register indexes of the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_MODE       = 3'd0,
        CFG_PROMPT_MIN = 3'd1,
        CFG_PROMPT_MAX = 3'd2,
        CFG_DELAY_MIN  = 3'd3,
        CFG_DELAY_MAX  = 3'd4,
        CFG_GAP_LOW    = 3'd5,
        CFG_GAP_HIGH   = 3'd6
    } cfg_idx_t;

    // energy selection modes
    localparam logic MODE_NARROW = 1'b0;
    localparam logic MODE_WIDE   = 1'b1;

    localparam logic [HitsW-1:0] TAG_HITS = 8'd2;

    localparam logic [ChainW-1:0]   RST_CHAIN      = 32'd1;
    localparam logic                RST_MODE       = MODE_NARROW;
    localparam logic [EnergyW-1:0]  RST_PROMPT_MIN = 17'd15870;
    localparam logic [EnergyW-1:0]  RST_PROMPT_MAX = 17'd16070;
    localparam logic [EnergyW-1:0]  RST_DELAY_MIN  = 17'd4800;
    localparam logic [EnergyW-1:0]  RST_DELAY_MAX  = 17'd5000;
    localparam logic [TimeW-1:0]    RST_GAP_LOW    = 40'd10;
    localparam logic [TimeW-1:0]    RST_GAP_HIGH   = 40'd1800000;

    typedef struct packed {
        logic [ChainW-1:0]   chain_id;
        logic [HitsW-1:0]    hit_count;
        logic [EnergyW-1:0]  sum_energy;
        logic [EnergyW-1:0]  part_energy_a;
        logic [EnergyW-1:0]  part_energy_b;
        logic [TimeW-1:0]    event_time;
        logic [ChannelW-1:0] detector_channel;
    } in_word_t;

    typedef struct packed {
        logic [EnergyW-1:0]  tag_prompt_energy;
        logic [TimeW-1:0]    tag_prompt_time;
        logic [ChannelW-1:0] tag_prompt_channel;
        logic [EnergyW-1:0]  tag_delayed_energy;
        logic [TimeW-1:0]    tag_delayed_time;
        logic [ChannelW-1:0] tag_delayed_channel;
    } out_word_t;

    typedef struct packed {
        logic                mode;
        logic [EnergyW-1:0]  prompt_min;
        logic [EnergyW-1:0]  prompt_max;
        logic [EnergyW-1:0]  delay_min;
        logic [EnergyW-1:0]  delay_max;
        logic [TimeW-1:0]    gap_low;
        logic [TimeW-1:0]    gap_high;
    } cfg_t;

endpackage

[rtl/core/pdct_in_stage.sv]
// input register holding one event word ahead of the evaluation stage
module pdct_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pdct_pkg::in_word_t in_data,
    input  logic               advance,
    output logic               held_valid,
    output pdct_pkg::in_word_t held_data
);

    logic               valid_reg;
    logic               valid_next;
    pdct_pkg::in_word_t data_reg;

    // a slot is free when empty or when its word moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

[rtl/core/pdct_eval.sv]
// prompt state, window tests and result register
module pdct_eval (
    input  logic                clk,
    input  logic                rst_n,
    input  pdct_pkg::cfg_t      cfg,
    input  logic                item_valid,
    input  pdct_pkg::in_word_t  item,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    output pdct_pkg::out_word_t out_data
);

    typedef struct packed {
        logic                          hit;
        logic [pdct_pkg::EnergyW-1:0]  energy;
    } pick_t;

    function automatic pick_t pick_energy(
        input logic                         mode,
        input logic [pdct_pkg::EnergyW-1:0] sum,
        input logic [pdct_pkg::EnergyW-1:0] ea,
        input logic [pdct_pkg::EnergyW-1:0] eb,
        input logic [pdct_pkg::EnergyW-1:0] lo,
        input logic [pdct_pkg::EnergyW-1:0] hi
    );
        pick_t r;
        r.hit    = 1'b0;
        r.energy = '0;
        if (mode == pdct_pkg::MODE_WIDE)
        begin
            if (sum > lo && sum < hi)
            begin
                r.hit    = 1'b1;
                r.energy = sum;
            end
        end
        else
        begin
            // second member wins when both pass
            if (eb > lo && eb < hi)
            begin
                r.hit    = 1'b1;
                r.energy = eb;
            end
            else if (ea > lo && ea < hi)
            begin
                r.hit    = 1'b1;
                r.energy = ea;
            end
        end
        return r;
    endfunction

    logic [pdct_pkg::ChainW-1:0]   chain_reg;
    logic                          have_reg;
    logic                          have_next;
    logic [pdct_pkg::EnergyW-1:0]  held_energy_reg;
    logic [pdct_pkg::TimeW-1:0]    held_time_reg;
    logic [pdct_pkg::ChannelW-1:0] held_channel_reg;
    logic                          res_valid_reg;
    logic                          res_valid_next;
    pdct_pkg::out_word_t           res_reg;
    pdct_pkg::out_word_t           res_next;

    logic                          go;
    logic                          have_eff;
    logic                          hits_ok;
    pick_t                         prompt_pick;
    pick_t                         delayed_pick;
    logic [pdct_pkg::TimeW-1:0]    gap;
    logic                          gap_ok;
    logic                          take_prompt;
    logic                          tag_hit;

    assign advance = !res_valid_reg || out_ready;
    assign go      = item_valid && advance;

    // a new chain drops the stored prompt before the event is judged
    assign have_eff = have_reg && (item.chain_id == chain_reg);
    assign hits_ok  = (item.hit_count == pdct_pkg::TAG_HITS);

    assign prompt_pick  = pick_energy(cfg.mode, item.sum_energy, item.part_energy_a,
                                      item.part_energy_b, cfg.prompt_min, cfg.prompt_max);
    assign delayed_pick = pick_energy(cfg.mode, item.sum_energy, item.part_energy_a,
                                      item.part_energy_b, cfg.delay_min, cfg.delay_max);

    assign gap    = item.event_time - held_time_reg;
    assign gap_ok = (item.event_time > held_time_reg) && (gap > cfg.gap_low)
                    && (gap < cfg.gap_high);

    assign take_prompt = hits_ok && !have_eff && prompt_pick.hit;
    assign tag_hit     = hits_ok && have_eff && gap_ok && delayed_pick.hit;
    assign have_next   = have_eff || take_prompt;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (go)
        begin
            res_valid_next = tag_hit;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
        res_next.tag_prompt_energy   = held_energy_reg;
        res_next.tag_prompt_time     = held_time_reg;
        res_next.tag_prompt_channel  = held_channel_reg;
        res_next.tag_delayed_energy  = delayed_pick.energy;
        res_next.tag_delayed_time    = item.event_time;
        res_next.tag_delayed_channel = item.detector_channel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg     <= pdct_pkg::RST_CHAIN;
            have_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (go)
            begin
                chain_reg <= item.chain_id;
                have_reg  <= have_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && take_prompt)
        begin
            held_energy_reg  <= prompt_pick.energy;
            held_time_reg    <= item.event_time;
            held_channel_reg <= item.detector_channel;
        end
        if (go && tag_hit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

[rtl/core/prompt_delayed_coincidence_tagger_core.sv]
// top level of the prompt/delayed coincidence tagger with its register file
// a tagged word passes the input register and then the result register before its tag reaches the outputs
// throughput: one event word per cycle while no stalled result holds the evaluation stage
// a stalled result holds the evaluation stage; the input register still takes one word
// reset clears the stored prompt, sets the current chain to one
// and loads the default window registers
module prompt_delayed_coincidence_tagger_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pdct_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pdct_pkg::out_word_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pdct_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [pdct_pkg::CfgDataW-1:0]       cfg_data
);

    pdct_pkg::cfg_t     cfg_reg;
    logic               advance;
    logic               item_valid;
    pdct_pkg::in_word_t item;

    // register writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= pdct_pkg::RST_MODE;
            cfg_reg.prompt_min <= pdct_pkg::RST_PROMPT_MIN;
            cfg_reg.prompt_max <= pdct_pkg::RST_PROMPT_MAX;
            cfg_reg.delay_min  <= pdct_pkg::RST_DELAY_MIN;
            cfg_reg.delay_max  <= pdct_pkg::RST_DELAY_MAX;
            cfg_reg.gap_low    <= pdct_pkg::RST_GAP_LOW;
            cfg_reg.gap_high   <= pdct_pkg::RST_GAP_HIGH;
        end
        else if (cfg_valid)
        begin
            case (pdct_pkg::cfg_idx_t'(cfg_index))
                pdct_pkg::CFG_MODE:
                    cfg_reg.mode <= cfg_data[0];
                pdct_pkg::CFG_PROMPT_MIN:
                    cfg_reg.prompt_min <= cfg_data[pdct_pkg::EnergyW-1:0];
                pdct_pkg::CFG_PROMPT_MAX:
                    cfg_reg.prompt_max <= cfg_data[pdct_pkg::EnergyW-1:0];
                pdct_pkg::CFG_DELAY_MIN:
                    cfg_reg.delay_min <= cfg_data[pdct_pkg::EnergyW-1:0];
                pdct_pkg::CFG_DELAY_MAX:
                    cfg_reg.delay_max <= cfg_data[pdct_pkg::EnergyW-1:0];
                pdct_pkg::CFG_GAP_LOW:
                    cfg_reg.gap_low <= cfg_data[pdct_pkg::TimeW-1:0];
                pdct_pkg::CFG_GAP_HIGH:
                    cfg_reg.gap_high <= cfg_data[pdct_pkg::TimeW-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register: parts the upstream handshake from evaluation
    pdct_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .advance    (advance),
        .held_valid (item_valid),
        .held_data  (item)
    );

    // evaluation: chain tracking, prompt capture, delayed match, result word
    pdct_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

[tb/coincidence_tag_checker.sv]
// channel monitor, tag prediction and comparison for the coincidence tagger
module coincidence_tag_checker
    import pdct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  in_word_t            in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  out_word_t           out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output int                  mismatches,
    output int                  tags_owed
);

    // shadow registers and coincidence state
    cfg_t                win;
    logic [ChainW-1:0]   chain_now;
    logic                armed;
    logic [EnergyW-1:0]  held_energy;
    logic [TimeW-1:0]    held_time;
    logic [ChannelW-1:0] held_channel;

    out_word_t owed_tags[$];
    int fail_count = 0;
    int owed_count = 0;

    assign mismatches = fail_count;
    assign tags_owed  = owed_count;

    task automatic flag(input string msg);
        fail_count++;
        $display("tag check: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // energy that passes the window; in narrow mode the second member wins
    function automatic bit energy_select(input in_word_t ev,
                                         input logic [EnergyW-1:0] lo,
                                         input logic [EnergyW-1:0] hi,
                                         output logic [EnergyW-1:0] e);
        bit hit = 1'b0;
        e = '0;
        if (win.mode == MODE_WIDE)
        begin
            if (ev.sum_energy > lo && ev.sum_energy < hi)
            begin
                e = ev.sum_energy;
                hit = 1'b1;
            end
        end
        else
        begin
            if (ev.part_energy_a > lo && ev.part_energy_a < hi)
            begin
                e = ev.part_energy_a;
                hit = 1'b1;
            end
            if (ev.part_energy_b > lo && ev.part_energy_b < hi)
            begin
                e = ev.part_energy_b;
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    task automatic tag_event(input in_word_t ev);
        logic [EnergyW-1:0] e;
        logic [TimeW-1:0]   delay;
        out_word_t          tag;
        if (ev.chain_id != chain_now)
        begin
            armed = 1'b0;
            chain_now = ev.chain_id;
        end
        if (ev.hit_count != TAG_HITS)
            return;
        if (!armed)
        begin
            if (energy_select(ev, win.prompt_min, win.prompt_max, e))
            begin
                armed = 1'b1;
                held_energy = e;
                held_time = ev.event_time;
                held_channel = ev.detector_channel;
            end
            return;
        end
        if (ev.event_time <= held_time)
            return;
        delay = ev.event_time - held_time;
        if (!(delay > win.gap_low && delay < win.gap_high))
            return;
        if (!energy_select(ev, win.delay_min, win.delay_max, e))
            return;
        tag.tag_prompt_energy   = held_energy;
        tag.tag_prompt_time     = held_time;
        tag.tag_prompt_channel  = held_channel;
        tag.tag_delayed_energy  = e;
        tag.tag_delayed_time    = ev.event_time;
        tag.tag_delayed_channel = ev.detector_channel;
        owed_tags = {owed_tags, tag};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            win.mode       = RST_MODE;
            win.prompt_min = RST_PROMPT_MIN;
            win.prompt_max = RST_PROMPT_MAX;
            win.delay_min  = RST_DELAY_MIN;
            win.delay_max  = RST_DELAY_MAX;
            win.gap_low    = RST_GAP_LOW;
            win.gap_high   = RST_GAP_HIGH;
            chain_now      = RST_CHAIN;
            armed          = 1'b0;
            held_energy    = '0;
            held_time      = '0;
            held_channel   = '0;
            owed_tags.delete();
        end
        else
        begin
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
            begin
                case (cfg_index)
                    CFG_MODE:       win.mode       = cfg_data[0];
                    CFG_PROMPT_MIN: win.prompt_min = cfg_data[EnergyW-1:0];
                    CFG_PROMPT_MAX: win.prompt_max = cfg_data[EnergyW-1:0];
                    CFG_DELAY_MIN:  win.delay_min  = cfg_data[EnergyW-1:0];
                    CFG_DELAY_MAX:  win.delay_max  = cfg_data[EnergyW-1:0];
                    CFG_GAP_LOW:    win.gap_low    = cfg_data[TimeW-1:0];
                    CFG_GAP_HIGH:   win.gap_high   = cfg_data[TimeW-1:0];
                    default: ;
                endcase
            end
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (owed_tags.size() == 0)
                    flag($sformatf("tag with none expected: %h", out_data));
                else
                begin
                    want = owed_tags.pop_front();
                    check_field("prompt energy", 64'(out_data.tag_prompt_energy),
                                64'(want.tag_prompt_energy));
                    check_field("prompt time", 64'(out_data.tag_prompt_time),
                                64'(want.tag_prompt_time));
                    check_field("prompt channel", 64'(out_data.tag_prompt_channel),
                                64'(want.tag_prompt_channel));
                    check_field("delayed energy", 64'(out_data.tag_delayed_energy),
                                64'(want.tag_delayed_energy));
                    check_field("delayed time", 64'(out_data.tag_delayed_time),
                                64'(want.tag_delayed_time));
                    check_field("delayed channel", 64'(out_data.tag_delayed_channel),
                                64'(want.tag_delayed_channel));
                end
            end
            if (in_valid === 1'b1 && in_ready === 1'b1)
                tag_event(in_data);
        end
        owed_count = owed_tags.size();
    end

endmodule

[tb/prompt_delayed_coincidence_tagger_core_tb.sv]
// stimulus and verdict for the prompt/delayed coincidence tagger
module prompt_delayed_coincidence_tagger_core_tb;
    import pdct_pkg::*;

    // unused register slot, written once to show it changes nothing
    localparam logic [CfgIdxW-1:0] CFG_SPARE   = 3'd7;
    localparam logic [63:0]        ENERGY_MASK = 64'h1_FFFF;
    localparam logic [63:0]        TIME_MASK   = 64'hFF_FFFF_FFFF;
    localparam logic [TimeW-1:0]   TIME_TOP    = 40'hFF_FFFF_FFFF;
    localparam int                 PHASES      = 8;
    localparam int                 PHASE_WORDS = 144;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    in_word_t            in_data   = '0;
    logic                out_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;
    logic                in_ready;
    logic                out_valid;
    out_word_t           out_data;
    logic                cfg_ready;
    int                  mismatches;
    int                  tags_owed;

    // stimulus-side copy of the window registers, used only to aim events
    cfg_t knobs;
    // set during the stretch where neither side idles
    bit   calm = 1'b0;

    always #1 clk = ~clk;

    prompt_delayed_coincidence_tagger_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    coincidence_tag_checker tag_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .tags_owed  (tags_owed)
    );

    // tag receiver: stalls about a third of the cycles, never when calm
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 36);
    end

    // hard stop in case the block hangs
    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [TimeW-1:0] rand40();
        return TimeW'({$urandom, $urandom});
    endfunction

    // value around a window: both edges, just inside, anywhere inside, or anything
    function automatic logic [63:0] near_window(input logic [63:0] lo,
                                                input logic [63:0] hi,
                                                input logic [63:0] full);
        logic [63:0] span;
        case ($urandom_range(11))
            0: return lo;
            1: return hi;
            2: return (lo + 1) & full;
            3: return (hi - 1) & full;
            4: return {$urandom, $urandom} & full;
            default: ;
        endcase
        if (hi > lo + 1)
        begin
            span = hi - lo - 1;
            return lo + 1 + ({$urandom, $urandom} % span);
        end
        return {$urandom, $urandom} & full;
    endfunction

    function automatic logic [EnergyW-1:0] near_energy(input logic [EnergyW-1:0] lo,
                                                       input logic [EnergyW-1:0] hi);
        return EnergyW'(near_window(64'(lo), 64'(hi), ENERGY_MASK));
    endfunction

    function automatic logic [EnergyW-1:0] rand_energy();
        return EnergyW'($urandom);
    endfunction

    // one multiplicity-two event whose selected energy is aimed at a window
    function automatic in_word_t aimed_event(input logic [ChainW-1:0] chain,
                                             input logic [TimeW-1:0] stamp,
                                             input logic [EnergyW-1:0] lo,
                                             input logic [EnergyW-1:0] hi);
        in_word_t w;
        w.chain_id         = chain;
        w.hit_count        = TAG_HITS;
        w.event_time       = stamp;
        w.detector_channel = ChannelW'($urandom);
        if (knobs.mode == MODE_WIDE)
        begin
            w.sum_energy    = near_energy(lo, hi);
            w.part_energy_a = ($urandom_range(1) == 0) ? near_energy(lo, hi)
                                                       : rand_energy();
            w.part_energy_b = rand_energy();
        end
        else
        begin
            // often both members land in the window, so the second must win
            w.sum_energy    = ($urandom_range(1) == 0) ? near_energy(lo, hi)
                                                       : rand_energy();
            w.part_energy_a = ($urandom_range(3) == 0) ? rand_energy()
                                                       : near_energy(lo, hi);
            w.part_energy_b = ($urandom_range(3) == 0) ? rand_energy()
                                                       : near_energy(lo, hi);
        end
        return w;
    endfunction

    function automatic in_word_t fixed_event(input logic [ChainW-1:0] chain,
                                             input logic [HitsW-1:0] hits,
                                             input logic [EnergyW-1:0] ea,
                                             input logic [EnergyW-1:0] eb,
                                             input logic [TimeW-1:0] stamp,
                                             input logic [ChannelW-1:0] chan);
        in_word_t w;
        w.chain_id         = chain;
        w.hit_count        = hits;
        w.sum_energy       = rand_energy();
        w.part_energy_a    = ea;
        w.part_energy_b    = eb;
        w.event_time       = stamp;
        w.detector_channel = chan;
        return w;
    endfunction

    function automatic cfg_t random_setting(input logic m);
        cfg_t        s;
        int unsigned lo;
        s.mode = m;
        lo = $urandom_range(0, 120000);
        s.prompt_min = EnergyW'(lo);
        s.prompt_max = EnergyW'(lo + $urandom_range(2, 8000));
        lo = $urandom_range(0, 120000);
        s.delay_min = EnergyW'(lo);
        s.delay_max = EnergyW'(lo + $urandom_range(2, 8000));
        s.gap_low  = TimeW'($urandom_range(0, 5000));
        s.gap_high = s.gap_low + TimeW'($urandom_range(2, 3000000));
        return s;
    endfunction

    // hand one event word over, idling first at random
    task automatic send_event(input in_word_t w);
        while (!calm && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    // valid stays up across back-to-back writes; the caller lowers it
    task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                             input logic [CfgDataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
    endtask

    // write all seven registers, with junk in the unused upper data bits
    task automatic apply_setting(input cfg_t s);
        logic [CfgDataW-1:0] junk;
        junk = rand40();
        junk[0] = s.mode;
        write_reg(CFG_MODE, junk);
        junk = rand40();
        junk[EnergyW-1:0] = s.prompt_min;
        write_reg(CFG_PROMPT_MIN, junk);
        junk = rand40();
        junk[EnergyW-1:0] = s.prompt_max;
        write_reg(CFG_PROMPT_MAX, junk);
        junk = rand40();
        junk[EnergyW-1:0] = s.delay_min;
        write_reg(CFG_DELAY_MIN, junk);
        junk = rand40();
        junk[EnergyW-1:0] = s.delay_max;
        write_reg(CFG_DELAY_MAX, junk);
        write_reg(CFG_GAP_LOW, s.gap_low);
        write_reg(CFG_GAP_HIGH, s.gap_high);
        cfg_valid <= 1'b0;
        knobs = s;
    endtask

    // stop sending, let every owed tag come back, then cover the pipeline
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tags_owed != 0);
        repeat (6) @(posedge clk);
    endtask

    // mostly prompt-then-delayed sequences, the rest raw noise
    task automatic random_burst(input int goal);
        int                done;
        int                k;
        int                reps;
        logic [ChainW-1:0] chain;
        logic [TimeW-1:0]  base;
        logic [TimeW-1:0]  stamp;
        in_word_t          w;
        done  = 0;
        chain = $urandom;
        while (done < goal)
        begin
            if ($urandom_range(99) < 75)
            begin
                // new chain half the time, so a fresh prompt can be taken
                if ($urandom_range(1) == 0)
                    chain = ($urandom_range(3) == 0) ? chain + 1 : $urandom;
                base = ($urandom_range(7) == 0) ? rand40() : (rand40() >> 1);
                send_event(aimed_event(chain, base, knobs.prompt_min, knobs.prompt_max));
                done++;
                reps = $urandom_range(1, 6);
                for (k = 0; k < reps; k++)
                begin
                    stamp = base + TimeW'(near_window(64'(knobs.gap_low),
                                                      64'(knobs.gap_high), TIME_MASK));
                    // now and then at or before the prompt
                    if ($urandom_range(15) == 0)
                        stamp = base - TimeW'($urandom_range(0, 3));
                    w = aimed_event(chain, stamp, knobs.delay_min, knobs.delay_max);
                    if ($urandom_range(9) == 0)
                        w.hit_count = HitsW'($urandom);
                    send_event(w);
                    done++;
                end
            end
            else
            begin
                w.chain_id         = ($urandom_range(1) == 0) ? chain : 32'($urandom);
                w.hit_count        = ($urandom_range(2) == 0) ? TAG_HITS : 8'($urandom);
                w.sum_energy       = rand_energy();
                w.part_energy_a    = rand_energy();
                w.part_energy_b    = rand_energy();
                w.event_time       = rand40();
                w.detector_channel = ChannelW'($urandom);
                send_event(w);
                done++;
            end
        end
    endtask

    initial
    begin
        cfg_t s;
        int   phase;

        knobs = '{mode: RST_MODE, prompt_min: RST_PROMPT_MIN,
                  prompt_max: RST_PROMPT_MAX, delay_min: RST_DELAY_MIN,
                  delay_max: RST_DELAY_MAX, gap_low: RST_GAP_LOW,
                  gap_high: RST_GAP_HIGH};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words on the reset windows: narrow mode, chain one
        // multiplicity not two is ignored even with a prompt energy
        send_event(fixed_event(32'd1, 8'd0, 17'd15900, 17'd15900, 40'd900, 10'd1023));
        send_event(fixed_event(32'd1, 8'd255, 17'd15900, 17'd15900, 40'd900, 10'd1023));
        // energies on the window edges do not pass
        send_event(fixed_event(32'd1, TAG_HITS, 17'd15870, 17'd16070, 40'd950, 10'd3));
        // prompt from the first member
        send_event(fixed_event(32'd1, TAG_HITS, 17'd15871, 17'd0, 40'd1000, 10'd5));
        // delay equal to the lower gap bound fails, one more passes
        send_event(fixed_event(32'd1, TAG_HITS, 17'd4900, 17'd0, 40'd1010, 10'd6));
        send_event(fixed_event(32'd1, TAG_HITS, 17'd4900, 17'd0, 40'd1011, 10'd7));
        // both members in the delayed window: the second one is tagged
        send_event(fixed_event(32'd1, TAG_HITS, 17'd4850, 17'd4950, 40'd1011, 10'd8));
        // delayed word at or before the prompt time
        send_event(fixed_event(32'd1, TAG_HITS, 17'd4900, 17'd4900, 40'd1000, 10'd9));
        send_event(fixed_event(32'd1, TAG_HITS, 17'd4900, 17'd4900, 40'd999, 10'd10));
        // upper gap bound fails, one less passes, only the first member inside
        send_event(fixed_event(32'd1, TAG_HITS, 17'd4900, 17'd0, 40'd1801000, 10'd11));
        send_event(fixed_event(32'd1, TAG_HITS, 17'd4801, 17'd4800, 40'd1800999, 10'd12));
        // a chain change clears the prompt and is then itself a prompt
        send_event(fixed_event(32'd7, TAG_HITS, 17'd16069, 17'd0, 40'd5000, 10'd13));
        send_event(fixed_event(32'd7, TAG_HITS, 17'd0, 17'd4999, 40'd6000, 10'd14));
        // a chain change with an ignored multiplicity still clears the prompt
        send_event(fixed_event(32'hFFFF_FFFF, 8'd3, 17'd15900, 17'd0, 40'd6500, 10'd15));
        send_event(fixed_event(32'hFFFF_FFFF, TAG_HITS, 17'd4900, 17'd0, 40'd7000, 10'd16));
        // prompt and tag near the top of the time range
        send_event(fixed_event(32'hFFFF_FFFF, TAG_HITS, 17'd15900, 17'd16000,
                               TIME_TOP - 40'd100, 10'd0));
        send_event(fixed_event(32'hFFFF_FFFF, TAG_HITS, 17'd4900, 17'd4901,
                               TIME_TOP, 10'd1023));
        // full-scale and zero energies pass nothing
        send_event(fixed_event(32'hFFFF_FFFF, TAG_HITS, 17'h1_FFFF, 17'h1_FFFF,
                               TIME_TOP, 10'd1023));
        send_event(fixed_event(32'd0, TAG_HITS, 17'd0, 17'd0, 40'd0, 10'd0));

        // random phases, each under its own register setting
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            s = random_setting(MODE_NARROW);
            case (phase)
                1:
                begin
                    // reset windows in wide mode; spare slot poked first
                    s = knobs;
                    s.mode = MODE_WIDE;
                    write_reg(CFG_SPARE, rand40());
                    apply_setting(s);
                end
                2:
                begin
                    // every window fully open
                    s.mode = MODE_NARROW;
                    s.prompt_min = '0;
                    s.prompt_max = '1;
                    s.delay_min  = '0;
                    s.delay_max  = '1;
                    s.gap_low    = '0;
                    s.gap_high   = '1;
                    apply_setting(s);
                end
                3: apply_setting(random_setting(MODE_WIDE));
                4: apply_setting(s);
                5:
                begin
                    // empty delayed window, no tag possible
                    s.delay_max = s.delay_min;
                    apply_setting(s);
                end
                6:
                begin
                    // empty gap window, single-value prompt window
                    s = random_setting(MODE_WIDE);
                    s.gap_high   = s.gap_low;
                    s.prompt_max = s.prompt_min + 17'd2;
                    apply_setting(s);
                end
                7:
                begin
                    // prompt window reaching both ends of the energy range
                    s = random_setting(1'($urandom_range(1)));
                    s.prompt_min = '0;
                    s.prompt_max = '1;
                    s.delay_min  = '0;
                    apply_setting(s);
                end
                default: ;
            endcase
            calm = (phase == 3);
            random_burst(PHASE_WORDS);
            calm = 1'b0;
        end

        wait_drained();
        repeat (20) @(posedge clk);

        if (mismatches == 0 && tags_owed == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
